// ===== sv/julia_set_pixel_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// julia_set_pixel_classifier_assert
// Assertion macros used by the checker file of the pixel classifier.
// ----------------------------------------------------------------------------
`ifndef JULIA_SET_PIXEL_CLASSIFIER_ASSERT_SVH
`define JULIA_SET_PIXEL_CLASSIFIER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define JSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define JSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/jsc_pkg.sv =====
// ----------------------------------------------------------------------------
// jsc_pkg
// Types, constants and sequencer states of the Julia set pixel classifier.
// ----------------------------------------------------------------------------
package jsc_pkg;

	localparam int MAX_SIDE  = 1024;
	localparam int FRAC_BITS = 28;
	localparam int DEFAULT_ITERATIONS = 200;

	localparam int IDX_W  = 10;             // pixel index width
	localparam int SIDE_W = 11;             // side register width
	localparam int DEN_W  = 10;             // side minus one
	localparam int NMAG_W = 11;             // |2k - (side-1)|
	localparam int Q_W    = 32;             // Q4.28 value
	localparam int PROD_W = 36;             // signed product after shift
	localparam int DIV_W  = NMAG_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int ITER_W = 8;

	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_NUM_ROWS   = 3'd0;
	localparam logic [2:0] REG_NUM_COLS   = 3'd1;
	localparam logic [2:0] REG_C_REAL     = 3'd2;
	localparam logic [2:0] REG_C_IMAG     = 3'd3;
	localparam logic [2:0] REG_ITERATIONS = 3'd4;

	localparam logic [SIDE_W-1:0] RST_NUM_ROWS = 11'd25;
	localparam logic [SIDE_W-1:0] RST_NUM_COLS = 11'd40;
	localparam logic [Q_W-1:0]    RST_C_REAL   = 32'd26843546;
	localparam logic [Q_W-1:0]    RST_C_IMAG   = 32'd222801428;
	localparam logic [ITER_W-1:0] RST_ITERATIONS = ITER_W'(DEFAULT_ITERATIONS);

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] column;
	} pix_t;

	typedef struct packed {
		logic inside_res;
		logic row_end;
	} res_t;

	typedef struct packed {
		logic              start;
		logic              neg;
		logic [NMAG_W-1:0] num_mag;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_COL,
		ST_DIV_ROW,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_RI,
		ST_UPDATE,
		ST_FINISH
	} state_t;

endpackage

// ===== sv/jsc_div.sv =====
// ----------------------------------------------------------------------------
// jsc_div
// Serial restoring divider for the start point, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jsc_div (
	input  logic            clk,
	input  logic            arst_n,
	input  jsc_pkg::div_req_t req,
	output jsc_pkg::div_rsp_t rsp
);
	import jsc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             ge;
	logic             sat_pos;
	logic             sat_neg;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= {req.num_mag, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	// Saturate the truncated quotient to the Q4.28 range.
	assign sat_pos = |quo_q[DIV_W-1:Q_W-1];
	assign sat_neg = (|quo_q[DIV_W-1:Q_W]) || (quo_q[Q_W-1] && (|quo_q[Q_W-2:0]));

	always_comb begin
		rsp.done = done_q;
		if (neg_q) begin
			rsp.quo = sat_neg ? {1'b1, {(Q_W-1){1'b0}}} : (~quo_q[Q_W-1:0] + 1'b1);
		end else begin
			rsp.quo = sat_pos ? {1'b0, {(Q_W-1){1'b1}}} : quo_q[Q_W-1:0];
		end
	end

endmodule

// ===== sv/julia_set_pixel_classifier.sv =====
// ----------------------------------------------------------------------------
// julia_set_pixel_classifier
// Escape-time classifier: maps a pixel to z, iterates z = z*z - c in Q4.28.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  pix     | in        | pix_valid / pix_ready  | row, column
//  res     | out       | res_valid / res_ready  | inside_res, row_end
//  apb     | in        | psel, penable, pready  | paddr, pwdata, prdata
//
//  One item runs two serial divisions for the start point, then per
//  iteration the steps zr*zr, zi*zi, zr*zi on the one shared 32x32
//  multiplier and, unless the pixel escapes or the count runs out,
//  the update. pix_ready is high only while no item is in flight. A
//  finished result waits in the output register, so the next item is
//  taken while res_ready is held low.
//  Reset loads the default image size, c and iteration count.
//
module julia_set_pixel_classifier (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  jsc_pkg::pix_t              pix,
	output logic                       res_valid,
	input  logic                       res_ready,
	output jsc_pkg::res_t              res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jsc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import jsc_pkg::*;

	localparam logic signed [PROD_W:0] FOUR = (PROD_W+1)'(4) <<< FRAC_BITS;

	// Clamp a side register to [2, MAX_SIDE].
	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
		if (s < SIDE_W'(2)) begin
			return SIDE_W'(2);
		end
		if (s > SIDE_W'(MAX_SIDE)) begin
			return SIDE_W'(MAX_SIDE);
		end
		return s;
	endfunction

	// Saturate a wide sum to the Q4.28 range.
	function automatic logic [Q_W-1:0] sat_q(input logic signed [PROD_W+1:0] v);
		if (v > $signed({{(PROD_W+2-Q_W){1'b0}}, {1'b0, {(Q_W-1){1'b1}}}})) begin
			return {1'b0, {(Q_W-1){1'b1}}};
		end
		if (v < $signed({{(PROD_W+2-Q_W){1'b1}}, {1'b1, {(Q_W-1){1'b0}}}})) begin
			return {1'b1, {(Q_W-1){1'b0}}};
		end
		return v[Q_W-1:0];
	endfunction

	// Configuration registers.
	logic [SIDE_W-1:0] num_rows_q;
	logic [SIDE_W-1:0] num_cols_q;
	logic [Q_W-1:0]    c_real_q;
	logic [Q_W-1:0]    c_imag_q;
	logic [ITER_W-1:0] iterations_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q   <= RST_NUM_ROWS;
			num_cols_q   <= RST_NUM_COLS;
			c_real_q     <= RST_C_REAL;
			c_imag_q     <= RST_C_IMAG;
			iterations_q <= RST_ITERATIONS;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_NUM_ROWS:   num_rows_q   <= pwdata[SIDE_W-1:0];
				REG_NUM_COLS:   num_cols_q   <= pwdata[SIDE_W-1:0];
				REG_C_REAL:     c_real_q     <= pwdata[Q_W-1:0];
				REG_C_IMAG:     c_imag_q     <= pwdata[Q_W-1:0];
				REG_ITERATIONS: iterations_q <= pwdata[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_NUM_ROWS:   prdata = {{(32-SIDE_W){1'b0}}, num_rows_q};
			REG_NUM_COLS:   prdata = {{(32-SIDE_W){1'b0}}, num_cols_q};
			REG_C_REAL:     prdata = c_real_q;
			REG_C_IMAG:     prdata = c_imag_q;
			REG_ITERATIONS: prdata = {{(32-ITER_W){1'b0}}, iterations_q};
			default:        prdata = '0;
		endcase
	end

	// Effective sides and their denominators.
	logic [SIDE_W-1:0] h_side;
	logic [SIDE_W-1:0] w_side;
	logic [SIDE_W-1:0] h_m1;
	logic [SIDE_W-1:0] w_m1;

	assign h_side = clamp_side(num_rows_q);
	assign w_side = clamp_side(num_cols_q);
	assign h_m1   = h_side - 1'b1;
	assign w_m1   = w_side - 1'b1;

	// Sequencer and datapath registers.
	state_t state_q, state_d;

	logic                     accept;
	logic [IDX_W-1:0]         row_q;
	logic                     row_end_q;
	logic                     inside_q;
	logic signed [Q_W-1:0]    zr_q;
	logic signed [Q_W-1:0]    zi_q;
	logic signed [PROD_W-1:0] rr_q;
	logic signed [PROD_W-1:0] ii_q;
	logic signed [PROD_W-1:0] ri_q;
	logic [ITER_W-1:0]        cnt_q;
	logic                     res_valid_q;
	res_t                     res_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                  escape;
	logic                  last_iter;
	logic                  out_free;
	logic signed [PROD_W:0] mag_sum;

	assign accept   = pix_valid & pix_ready;
	assign mag_sum  = {rr_q[PROD_W-1], rr_q} + {ii_q[PROD_W-1], ii_q};
	assign escape   = mag_sum >= FOUR;
	assign last_iter = (cnt_q == iterations_q);
	assign out_free = ~res_valid_q | res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pix_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pix_ready = 1'b1;
				if (pix_valid) begin
					state_d = ST_DIV_COL;
				end
			end
			ST_DIV_COL: begin
				if (div_rsp.done) begin
					state_d = ST_DIV_ROW;
				end
			end
			ST_DIV_ROW: begin
				if (div_rsp.done) begin
					state_d = ST_MUL_RR;
				end
			end
			ST_MUL_RR: state_d = ST_MUL_II;
			ST_MUL_II: state_d = ST_MUL_RI;
			ST_MUL_RI: begin
				// Test |z|^2 while the cross product is formed.
				if (escape || last_iter) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_MUL_RR;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Start point requests: column first, then row.
	logic [IDX_W-1:0]  div_k;
	logic [DEN_W-1:0]  div_den;
	logic [NMAG_W:0]   div_n;

	always_comb begin
		if (state_q == ST_IDLE) begin
			div_k   = pix.column;
			div_den = w_m1[DEN_W-1:0];
		end else begin
			div_k   = row_q;
			div_den = h_m1[DEN_W-1:0];
		end
		div_n = {1'b0, div_k, 1'b0} - {2'b00, div_den};
		div_req.start   = accept || (state_q == ST_DIV_COL && div_rsp.done);
		div_req.neg     = div_n[NMAG_W];
		div_req.num_mag = div_n[NMAG_W] ? (~div_n[NMAG_W-1:0] + 1'b1)
		                                : div_n[NMAG_W-1:0];
		div_req.den     = div_den;
	end

	jsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Shared multiplier: magnitudes, product, shift, restore sign.
	logic signed [Q_W-1:0]    mul_a;
	logic signed [Q_W-1:0]    mul_b;
	logic [Q_W-1:0]           mag_a;
	logic [Q_W-1:0]           mag_b;
	logic [2*Q_W-1:0]         mul_full;
	logic [PROD_W-1:0]        mul_shr;
	logic signed [PROD_W-1:0] mul_res;

	always_comb begin
		case (state_q)
			ST_MUL_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			ST_MUL_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
		mag_a    = mul_a[Q_W-1] ? (~mul_a + 1'b1) : mul_a;
		mag_b    = mul_b[Q_W-1] ? (~mul_b + 1'b1) : mul_b;
		mul_full = mag_a * mag_b;
		mul_shr  = {1'b0, mul_full[FRAC_BITS +: PROD_W-1]};
		mul_res  = (mul_a[Q_W-1] ^ mul_b[Q_W-1]) ? $signed(~mul_shr + 1'b1)
		                                         : $signed(mul_shr);
	end

	// Next z from the registered products.
	logic signed [PROD_W+1:0] zr_wide;
	logic signed [PROD_W+1:0] zi_wide;

	assign zr_wide = {{2{rr_q[PROD_W-1]}}, rr_q} - {{2{ii_q[PROD_W-1]}}, ii_q}
	               - {{(PROD_W+2-Q_W){c_real_q[Q_W-1]}}, c_real_q};
	assign zi_wide = {ri_q[PROD_W-1], ri_q, 1'b0}
	               - {{(PROD_W+2-Q_W){c_imag_q[Q_W-1]}}, c_imag_q};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					row_q     <= pix.row;
					row_end_q <= (pix.column == w_m1[IDX_W-1:0]);
				end
			end
			ST_DIV_COL: begin
				if (div_rsp.done) begin
					zr_q <= div_rsp.quo;
				end
			end
			ST_DIV_ROW: begin
				if (div_rsp.done) begin
					zi_q  <= div_rsp.quo;
					cnt_q <= '0;
				end
			end
			ST_MUL_RR: rr_q <= mul_res;
			ST_MUL_II: ii_q <= mul_res;
			ST_MUL_RI: begin
				ri_q     <= mul_res;
				inside_q <= ~escape;
			end
			ST_UPDATE: begin
				zr_q  <= sat_q(zr_wide);
				zi_q  <= sat_q(zi_wide);
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Output register: hold the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			res_q.inside_res <= inside_q;
			res_q.row_end    <= row_end_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/jsc_checker.sv =====
// ----------------------------------------------------------------------------
// jsc_checker
// Port-level checks of the pixel classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "julia_set_pixel_classifier_assert.svh"

module jsc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pix_valid,
	input logic                       pix_ready,
	input jsc_pkg::pix_t              pix,
	input logic                       res_valid,
	input logic                       res_ready,
	input jsc_pkg::res_t              res,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [jsc_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata,
	input logic                       pready
);
	import jsc_pkg::*;

	// An accepted item keeps the block busy.
	`JSC_ASSERT_NEXT(busy_after_accept, clk, arst_n, pix_valid && pix_ready, !pix_ready, "ready stayed high after an item was taken")

	// A new result ends the work on the item in flight.
	`JSC_ASSERT_NOW(result_frees_input, clk, arst_n, $rose(res_valid), pix_ready && $past(!pix_ready), "result appeared without an item in flight")

	// Hold a stalled result.
	`JSC_ASSERT_NEXT(result_held, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res), "stalled result changed")

endmodule

bind julia_set_pixel_classifier jsc_checker u_jsc_checker (.*);
